/* sv/hsfd_pkg.sv */
package hsfd_pkg;

    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    // x^8 term of 0x131 is implicit in the shift
    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam int          FULL_SCALE = 65535;
    localparam logic [7:0]  T_SCALE    = 8'd175;
    localparam logic [6:0]  H_SCALE    = 7'd100;
    localparam int          T_OFFSET   = 50;
    localparam logic [23:0] T_OFFSET_SCALED = 24'(T_OFFSET * FULL_SCALE);

    localparam int QUEUE_DEPTH_DEF = 4;

    // reply byte positions
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    typedef struct packed {
        logic        ok;
        logic [15:0] temp_word;
        logic [15:0] humid_word;
    } hsfd_rec_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535): x = q0*65536 + lo = q0*65535 + (lo + q0), one correction step
    function automatic logic [8:0] div_full_scale(input logic [23:0] x);
        logic [7:0]  q0;
        logic [16:0] r;
        q0 = x[23:16];
        r  = {1'b0, x[15:0]} + {9'd0, q0};
        return {1'b0, q0} + ((r >= 17'(FULL_SCALE)) ? 9'd1 : 9'd0);
    endfunction

endpackage

/* sv/humidity_sensor_frame_decoder_top.sv */
// Sensor reply decoder: six bytes in, one checked and converted reading out.
// Input channel: frame_byte/frame_start, taken at a clock edge with push high
// and full low. frame_start restarts the reply; after six bytes the count
// wraps on its own. Bytes are checked with CRC-8 (poly 0x31, seed 0xFF) per
// 16-bit word as they arrive.
// Result channel: crc_ok, temperature_c (signed degC), humidity_pct, valid
// while empty is low, taken at an edge with pop high. Both values read zero
// when either word check fails.
// Throughput: one byte per cycle, sustained while full is low. The sixth byte of a reply puts a
// record into a QUEUE_DEPTH-entry queue; a three-stage conversion pipeline
// (constant multiply, offset/divide, divide/sign) drains it, so the reading
// reaches the output through the queue and stages 1 to 3; a low pop can hold it.
// Stalls: when pop is held low the pipeline fills, then the queue; full rises
// only once the queue has QUEUE_DEPTH records waiting, so a stalled reader
// costs nothing until roughly QUEUE_DEPTH + 3 readings back up.
// Reset: asynchronous; clears the byte count, the CRC, the queue and the
// pipeline. No result is pending after reset.
module humidity_sensor_frame_decoder_top
    import hsfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        frame_byte,
    input  logic              frame_start,
    output logic              empty,
    input  logic              pop,
    output logic              crc_ok,
    output logic signed [7:0] temperature_c,
    output logic [6:0]        humidity_pct
);

    logic      accept;
    logic      rec_push;
    hsfd_rec_t rec_in;
    hsfd_rec_t rec_out;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_byte  (frame_byte),
        .frame_start (frame_start),
        .rec_push    (rec_push),
        .rec         (rec_in)
    );

    hsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (rec_out),
        .empty     (q_empty)
    );

    hsfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_empty     (q_empty),
        .rec           (rec_out),
        .rec_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .crc_ok        (crc_ok),
        .temperature_c (temperature_c),
        .humidity_pct  (humidity_pct)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(rec_push && q_full))
        else $error("record pushed into full queue");

    a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !crc_ok) |-> (temperature_c == 8'sd0 && humidity_pct == 7'd0))
        else $error("failed reply carries nonzero reading");

    a_humid_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (humidity_pct <= 7'd100))
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (temperature_c >= -8'sd50 && temperature_c <= 8'sd125))
        else $error("temperature out of range");

endmodule

/* sv/hsfd_front.sv */
module hsfd_front
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] frame_byte,
    input  logic       frame_start,
    output logic       rec_push,
    output hsfd_rec_t  rec
);

    logic [2:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic        temp_good_reg, temp_good_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] humid_word_reg, humid_word_next;
    logic [2:0]  pos;
    logic [7:0]  crc_seed;
    logic [7:0]  crc_step;

    always_comb
    begin
        if (frame_start || count_reg > POS_H_CRC)
            pos = POS_T_MSB;
        else
            pos = count_reg;

        crc_seed = (pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_reg;
        crc_step = crc8_byte(crc_seed, frame_byte);

        count_next      = count_reg;
        crc_next        = crc_reg;
        temp_good_next  = temp_good_reg;
        temp_word_next  = temp_word_reg;
        humid_word_next = humid_word_reg;

        if (accept)
        begin
            unique case (pos)
                POS_T_MSB:
                begin
                    temp_good_next = 1'b0;
                    temp_word_next = {frame_byte, 8'd0};
                    crc_next       = crc_step;
                    count_next     = POS_T_LSB;
                end
                POS_T_LSB:
                begin
                    temp_word_next = {temp_word_reg[15:8], frame_byte};
                    crc_next       = crc_step;
                    count_next     = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    temp_good_next = (crc_reg == frame_byte);
                    crc_next       = CRC_INIT;
                    count_next     = POS_H_MSB;
                end
                POS_H_MSB:
                begin
                    humid_word_next = {frame_byte, 8'd0};
                    crc_next        = crc_step;
                    count_next      = POS_H_LSB;
                end
                POS_H_LSB:
                begin
                    humid_word_next = {humid_word_reg[15:8], frame_byte};
                    crc_next        = crc_step;
                    count_next      = POS_H_CRC;
                end
                default:
                begin
                    crc_next   = CRC_INIT;
                    count_next = POS_T_MSB;
                end
            endcase
        end
    end

    assign rec_push       = accept && (pos == POS_H_CRC);
    assign rec.ok         = temp_good_reg && (crc_reg == frame_byte);
    assign rec.temp_word  = temp_word_reg;
    assign rec.humid_word = humid_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= POS_T_MSB;
            crc_reg       <= CRC_INIT;
            temp_good_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            temp_good_reg <= temp_good_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_word_reg  <= temp_word_next;
        humid_word_reg <= humid_word_next;
    end

endmodule

/* sv/hsfd_queue.sv */
module hsfd_queue
    import hsfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hsfd_rec_t push_data,
    output logic      full,
    input  logic      pop,
    output hsfd_rec_t pop_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hsfd_rec_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* sv/hsfd_back.sv */
module hsfd_back
    import hsfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_empty,
    input  hsfd_rec_t         rec,
    output logic              rec_pop,
    output logic              empty,
    input  logic              pop,
    output logic              crc_ok,
    output logic signed [7:0] temperature_c,
    output logic [6:0]        humidity_pct
);

    // stage 1: scaled words
    logic        s1_v_reg;
    logic        s1_ok_reg;
    logic [23:0] s1_t_reg;
    logic [22:0] s1_h_reg;
    // stage 2: temperature offset removed, humidity divided
    logic        s2_v_reg;
    logic        s2_ok_reg;
    logic        s2_neg_reg;
    logic [23:0] s2_mag_reg;
    logic [6:0]  s2_h_reg;
    // stage 3: output register
    logic        s3_v_reg;
    logic        s3_ok_reg;
    logic [7:0]  s3_t_reg;
    logic [6:0]  s3_h_reg;

    logic        s1_free, s2_free, s3_free;
    logic        s2_neg_next;
    logic [23:0] s2_mag_next;
    logic [6:0]  s2_h_next;
    logic [8:0]  h_quot, t_quot;
    logic [7:0]  s3_t_next;

    assign s3_free = !s3_v_reg || pop;
    assign s2_free = !s2_v_reg || s3_free;
    assign s1_free = !s1_v_reg || s2_free;
    assign rec_pop = !rec_empty && s1_free;

    always_comb
    begin
        s2_neg_next = (s1_t_reg < T_OFFSET_SCALED);
        s2_mag_next = s2_neg_next ? (T_OFFSET_SCALED - s1_t_reg) : (s1_t_reg - T_OFFSET_SCALED);
        h_quot      = div_full_scale({1'b0, s1_h_reg});
        s2_h_next   = h_quot[6:0];

        t_quot      = div_full_scale(s2_mag_reg);
        s3_t_next   = s2_neg_reg ? (~t_quot[7:0] + 8'd1) : t_quot[7:0];
        if (!s2_ok_reg)
            s3_t_next = 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_v_reg <= rec_pop;
            if (s2_free)
                s2_v_reg <= s1_v_reg;
            if (s3_free)
                s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            s1_ok_reg <= rec.ok;
            s1_t_reg  <= 24'(rec.temp_word * T_SCALE);
            s1_h_reg  <= 23'(rec.humid_word * H_SCALE);
        end
        if (s2_free && s1_v_reg)
        begin
            s2_ok_reg  <= s1_ok_reg;
            s2_neg_reg <= s2_neg_next;
            s2_mag_reg <= s2_mag_next;
            s2_h_reg   <= s2_h_next;
        end
        if (s3_free && s2_v_reg)
        begin
            s3_ok_reg <= s2_ok_reg;
            s3_t_reg  <= s3_t_next;
            s3_h_reg  <= s2_ok_reg ? s2_h_reg : 7'd0;
        end
    end

    assign empty         = !s3_v_reg;
    assign crc_ok        = s3_ok_reg;
    assign temperature_c = s3_t_reg;
    assign humidity_pct  = s3_h_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import hsfd_pkg::*;

    typedef struct {
        logic              ok;
        logic signed [7:0] temp;
        logic [6:0]        hum;
    } reading_t;

    // Tracks reply decoding alongside the block and holds the readings still owed.
    class reading_scoreboard;
        logic [2:0]  byte_pos;
        logic [7:0]  crc;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        temp_good;
        reading_t    pending_readings[$];
        int          errors;

        function new();
            byte_pos  = POS_T_MSB;
            crc       = CRC_INIT;
            temp_raw  = '0;
            hum_raw   = '0;
            temp_good = 1'b0;
            errors    = 0;
        endfunction

        static function logic [7:0] crc_step(input logic [7:0] c_in, input logic [7:0] b);
            logic [7:0] c;
            c = c_in ^ b;
            repeat (8)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
            return c;
        endfunction

        // -50 + 175*raw/65535, truncated toward zero
        static function logic signed [7:0] to_celsius(input logic [15:0] raw);
            int scaled;
            int offs;
            int r;
            scaled = 175 * int'(raw);
            offs   = 50 * 65535;
            if (scaled >= offs)
                r = (scaled - offs) / 65535;
            else
                r = -((offs - scaled) / 65535);
            return r[7:0];
        endfunction

        static function logic [6:0] to_percent(input logic [15:0] raw);
            int r;
            r = (100 * int'(raw)) / 65535;
            return r[6:0];
        endfunction

        function void note_byte(input logic [7:0] b, input logic start);
            logic [2:0] pos;
            reading_t   rd;
            pos = start ? POS_T_MSB : byte_pos;
            if (pos > POS_H_CRC)
                pos = POS_T_MSB;
            case (pos)
                POS_T_MSB:
                begin
                    temp_good = 1'b0;
                    temp_raw  = {b, 8'h00};
                    crc       = crc_step(CRC_INIT, b);
                end
                POS_T_LSB:
                begin
                    temp_raw[7:0] = b;
                    crc           = crc_step(crc, b);
                end
                POS_T_CRC:
                begin
                    temp_good = (crc == b);
                    crc       = CRC_INIT;
                end
                POS_H_MSB:
                begin
                    hum_raw = {b, 8'h00};
                    crc     = crc_step(CRC_INIT, b);
                end
                POS_H_LSB:
                begin
                    hum_raw[7:0] = b;
                    crc          = crc_step(crc, b);
                end
                default:
                begin
                    rd.ok   = temp_good && (crc == b);
                    rd.temp = rd.ok ? to_celsius(temp_raw) : 8'sd0;
                    rd.hum  = rd.ok ? to_percent(hum_raw) : 7'd0;
                    pending_readings.push_back(rd);
                    crc = CRC_INIT;
                end
            endcase
            byte_pos = (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
        endfunction

        function void check_reading(input logic ok, input logic signed [7:0] t,
                                    input logic [6:0] h);
            reading_t ex;
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected reading ok=%0b temp=%0d hum=%0d", $time, ok, t, h);
                errors++;
                return;
            end
            ex = pending_readings.pop_front();
            if (ok !== ex.ok)
            begin
                $display("%0t: crc_ok expected %0b actual %0b", $time, ex.ok, ok);
                errors++;
            end
            if (t !== ex.temp)
            begin
                $display("%0t: temperature_c expected %0d actual %0d", $time, ex.temp, t);
                errors++;
            end
            if (h !== ex.hum)
            begin
                $display("%0t: humidity_pct expected %0d actual %0d", $time, ex.hum, h);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 325;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        frame_byte = 8'h00;
    logic              frame_start = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic              crc_ok;
    logic signed [7:0] temperature_c;
    logic [6:0]        humidity_pct;

    reading_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    int idle_cycles = 0;

    humidity_sensor_frame_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .frame_byte   (frame_byte),
        .frame_start  (frame_start),
        .empty        (empty),
        .pop          (pop),
        .crc_ok       (crc_ok),
        .temperature_c(temperature_c),
        .humidity_pct (humidity_pct)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // reader: stalls at random, or holds off entirely when asked
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_reading(crc_ok, temperature_c, humidity_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("humidity_sensor_frame_decoder_top regression: fail");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push        <= 1'b1;
        frame_byte  <= b;
        frame_start <= start;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(b, start);
        bytes_sent++;
    endtask

    task automatic send_reply(input logic [15:0] t, input logic [15:0] h,
                              input logic t_bad, input logic h_bad, input logic start);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = reading_scoreboard::crc_step(reading_scoreboard::crc_step(CRC_INIT, t[15:8]), t[7:0]);
        hc = reading_scoreboard::crc_step(reading_scoreboard::crc_step(CRC_INIT, h[15:8]), h[7:0]);
        if (t_bad)
            tc ^= 8'($urandom_range(1, 255));
        if (h_bad)
            hc ^= 8'($urandom_range(1, 255));
        send_byte(t[15:8], start);
        send_byte(t[7:0], 1'b0);
        send_byte(tc, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(hc, 1'b0);
    endtask

    // sender stops and waits until every reading owed has come out
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending_readings.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_traffic(input int n_items);
        int first;
        int kind;
        int n;
        first = bytes_sent;
        while (bytes_sent - first < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
                send_reply(rand_word(), rand_word(), $urandom_range(9) == 0,
                           $urandom_range(9) == 0, $urandom_range(3) != 0);
            else if (kind < 90)
            begin
                // truncated reply, restarted only if what comes next carries the start flag
                n = $urandom_range(1, 5);
                send_byte(8'($urandom), 1'b1);
                repeat (n - 1) send_byte(8'($urandom), 1'b0);
            end
            else
                send_byte(8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_reply(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        // wraps after a complete reply with no start flag
        send_reply(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_reply(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
        // start flag mid-reply drops these two
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_reply(16'h4000, 16'h1234, 1'b0, 1'b1, 1'b1);
        drain();

        // full rate with a long reader hold-off so the block backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        random_traffic(PHASE_ITEMS);
        drain();

        send_idle_pct  = 80;
        recv_stall_pct = 0;
        random_traffic(PHASE_ITEMS);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 80;
        random_traffic(PHASE_ITEMS);
        drain();

        send_idle_pct  = 32;
        recv_stall_pct = 32;
        random_traffic(PHASE_ITEMS);
        drain();

        if (sb.pending_readings.size() != 0)
        begin
            $display("%0t: %0d readings never arrived", $time, sb.pending_readings.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("humidity_sensor_frame_decoder_top regression: pass");
        else
            $display("humidity_sensor_frame_decoder_top regression: fail");
        $finish;
    end

endmodule

/* files.f */
sv/hsfd_pkg.sv
sv/hsfd_front.sv
sv/hsfd_queue.sv
sv/hsfd_back.sv
sv/humidity_sensor_frame_decoder_top.sv
dv/testbench.sv
